FILE: design/dpcm_sample_playback_channel_defines.svh
`ifndef DPCM_SAMPLE_PLAYBACK_CHANNEL_DEFINES_SVH
`define DPCM_SAMPLE_PLAYBACK_CHANNEL_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DPCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dpcm_pkg.sv
`timescale 1ns / 1ps

package dpcm_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REVERSE = 2'd0,
    CFG_GLITCH  = 2'd1,
    CFG_POP     = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_DMA    = 3'd2,
    OP_ENABLE = 3'd3,
    OP_SRESET = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_FLAGS = 2'd0,
    REG_LEVEL = 2'd1,
    REG_ADDR  = 2'd2,
    REG_LEN   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    HINT_NONE  = 2'd0,
    HINT_SET   = 2'd1,
    HINT_CLEAR = 2'd2
  } hint_t;

  localparam logic [15:0] SAMPLE_BASE   = 16'hC000;
  localparam logic [15:0] FETCH_WRAP    = 16'h8000;
  localparam logic [9:0]  RESET_PERIOD  = 10'd427;
  localparam logic [6:0]  LEVEL_TOP     = 7'd125;
  localparam logic [6:0]  LEVEL_STEP    = 7'd2;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
  localparam logic [1:0]  STOP_GLITCH   = 2'd3;
  localparam logic signed [8:0] POP_LIMIT = 9'sd50;

  typedef struct packed {
    logic reverse_bit_order;
    logic duplication_glitch_enable;
    logic reduce_popping;
  } dpcm_cfg_t;

  typedef struct packed {
    logic [15:0] sample_start;
    logic [11:0] sample_len;
    logic [15:0] fetch_addr;
    logic [11:0] bytes_left;
    logic [7:0]  read_buf;
    logic        buf_empty;
    logic [7:0]  shifter;
    logic [3:0]  bits_left;
    logic        silent;
    logic [6:0]  out_level;
    logic        irq_on;
    logic        loop_on;
    logic [9:0]  timer_count;
    logic [9:0]  timer_period;
    logic [1:0]  start_delay;
    logic [1:0]  stop_delay;
    logic [6:0]  last_level_write;
  } dpcm_state_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] reg_index;
    logic [7:0] data;
    logic [9:0] rate_period;
    logic       odd_cycle;
    logic       enable;
  } dpcm_item_t;

  typedef struct packed {
    logic [6:0]  level;
    logic        level_valid;
    logic        dma_request;
    logic [15:0] dma_address;
    logic        dma_stop;
    logic        irq_raise;
    logic        irq_clear;
    logic        active;
    hint_t       overclock_hint;
  } dpcm_result_t;

  localparam dpcm_cfg_t CFG_RESET = '{default: 1'b0};

  localparam dpcm_state_t STATE_RESET = '{
    sample_start:     SAMPLE_BASE,
    sample_len:       12'd1,
    fetch_addr:       16'd0,
    bytes_left:       12'd0,
    read_buf:         8'd0,
    buf_empty:        1'b1,
    shifter:          8'd0,
    bits_left:        BITS_PER_BYTE,
    silent:           1'b1,
    out_level:        7'd0,
    irq_on:           1'b0,
    loop_on:          1'b0,
    timer_count:      RESET_PERIOD,
    timer_period:     RESET_PERIOD,
    start_delay:      2'd0,
    stop_delay:       2'd0,
    last_level_write: 7'd0
  };

endpackage

FILE: design/dpcm_sample_playback_channel.sv
`timescale 1ns / 1ps
// order: a beat taken is registered in item_r, then stepped through dpcm_step
// when the result register is free or draining; the result lands in res_r
// throughput: one item per clock unless out_ready stalls; single step stage
// reset: rst_n synchronous active low, restores the power-up channel state
// and clears all three mode registers; no clearing pass

module dpcm_sample_playback_channel (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dpcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpcm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_opcode,
  input  logic [1:0]                        in_reg_index,
  input  logic [7:0]                        in_data,
  input  logic [9:0]                        in_rate_period,
  input  logic                              in_odd_cycle,
  input  logic                              in_enable,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [6:0]                        out_level,
  output logic                              out_level_valid,
  output logic                              out_dma_request,
  output logic [15:0]                       out_dma_address,
  output logic                              out_dma_stop,
  output logic                              out_irq_raise,
  output logic                              out_irq_clear,
  output logic                              out_active,
  output logic [1:0]                        out_overclock_hint
);
  import dpcm_pkg::*;

  dpcm_cfg_t    cfg_r;
  dpcm_state_t  st_r;
  dpcm_state_t  st_nxt;
  dpcm_item_t   item_r;
  dpcm_result_t res_nxt;
  dpcm_result_t res_r;
  logic         in_vld_r;
  logic         out_vld_r;
  logic         advance;

  // step stage moves when the result register is free or being drained
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  dpcm_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= CFG_RESET;
      st_r      <= STATE_RESET;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REVERSE: cfg_r.reverse_bit_order         <= cfg_data[0];
          CFG_GLITCH:  cfg_r.duplication_glitch_enable <= cfg_data[0];
          CFG_POP:     cfg_r.reduce_popping            <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (in_ready) in_vld_r <= in_valid;
      if (advance) begin
        st_r      <= st_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{opcode:      in_opcode,
                  reg_index:   in_reg_index,
                  data:        in_data,
                  rate_period: in_rate_period,
                  odd_cycle:   in_odd_cycle,
                  enable:      in_enable};
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_level          = res_r.level;
  assign out_level_valid    = res_r.level_valid;
  assign out_dma_request    = res_r.dma_request;
  assign out_dma_address    = res_r.dma_address;
  assign out_dma_stop       = res_r.dma_stop;
  assign out_irq_raise      = res_r.irq_raise;
  assign out_irq_clear      = res_r.irq_clear;
  assign out_active         = res_r.active;
  assign out_overclock_hint = res_r.overclock_hint;

endmodule

FILE: design/dpcm_step.sv
`timescale 1ns / 1ps

module dpcm_step (
  input  dpcm_pkg::dpcm_state_t  st,
  input  dpcm_pkg::dpcm_cfg_t    cfg,
  input  dpcm_pkg::dpcm_item_t   item,
  output dpcm_pkg::dpcm_state_t  st_nxt,
  output dpcm_pkg::dpcm_result_t res
);
  import dpcm_pkg::*;

  logic              shift_bit;
  logic              req;
  logic [15:0]       addr_inc;
  logic [6:0]        nv;
  logic signed [8:0] diff;
  logic signed [8:0] half;
  logic signed [8:0] popped;
  logic              big_jump;
  logic [1:0]        delay;

  function automatic logic try_fetch(dpcm_state_t s);
    return s.buf_empty && (s.bytes_left != 12'd0);
  endfunction

  // level write: difference against the current level, halved toward zero
  assign nv       = item.data[6:0];
  assign diff     = $signed({2'b00, nv}) - $signed({2'b00, st.out_level});
  assign half     = (diff + $signed({8'b0, diff[8]})) >>> 1;
  assign popped   = $signed({2'b00, nv}) - half;
  assign big_jump = (diff > POP_LIMIT) || (diff < -POP_LIMIT);
  assign delay    = item.odd_cycle ? 2'd3 : 2'd2;
  assign addr_inc = st.fetch_addr + 16'd1;

  always_comb begin
    st_nxt    = st;
    shift_bit = 1'b0;
    req       = 1'b0;
    res       = '0;
    res.overclock_hint = HINT_NONE;
    case (item.opcode)
      OP_TICK: begin
        if (st_nxt.stop_delay != 2'd0) begin
          st_nxt.stop_delay = st_nxt.stop_delay - 2'd1;
          if (st_nxt.stop_delay == 2'd0) begin
            st_nxt.bytes_left = 12'd0;
            res.dma_stop      = 1'b1;
          end
        end
        if (st_nxt.start_delay != 2'd0) begin
          st_nxt.start_delay = st_nxt.start_delay - 2'd1;
          if (st_nxt.start_delay == 2'd0) req = req | try_fetch(st_nxt);
        end
        if (st_nxt.timer_count == 10'd0) begin
          st_nxt.timer_count = st_nxt.timer_period;
          if (!st_nxt.silent) begin
            if (cfg.reverse_bit_order) begin
              shift_bit      = st_nxt.shifter[7];
              st_nxt.shifter = {st_nxt.shifter[6:0], 1'b0};
            end else begin
              shift_bit      = st_nxt.shifter[0];
              st_nxt.shifter = {1'b0, st_nxt.shifter[7:1]};
            end
            if (shift_bit) begin
              if (st_nxt.out_level <= LEVEL_TOP) begin
                st_nxt.out_level = st_nxt.out_level + LEVEL_STEP;
              end
            end else if (st_nxt.out_level >= LEVEL_STEP) begin
              st_nxt.out_level = st_nxt.out_level - LEVEL_STEP;
            end
          end
          st_nxt.bits_left = st_nxt.bits_left - 4'd1;
          if (st_nxt.bits_left == 4'd0) begin
            st_nxt.bits_left = BITS_PER_BYTE;
            if (st_nxt.buf_empty) begin
              st_nxt.silent = 1'b1;
            end else begin
              st_nxt.silent    = 1'b0;
              st_nxt.shifter   = st_nxt.read_buf;
              st_nxt.buf_empty = 1'b1;
              if (st_nxt.start_delay == 2'd0) req = req | try_fetch(st_nxt);
            end
          end
          res.level_valid = 1'b1;
        end else begin
          st_nxt.timer_count = st_nxt.timer_count - 10'd1;
        end
      end
      OP_WRITE: begin
        case (item.reg_index)
          REG_FLAGS: begin
            st_nxt.irq_on       = item.data[7];
            st_nxt.loop_on      = item.data[6];
            st_nxt.timer_period = item.rate_period;
            res.irq_clear       = !item.data[7];
          end
          REG_LEVEL: begin
            st_nxt.out_level = (cfg.reduce_popping && big_jump) ? popped[6:0] : nv;
            res.level_valid  = 1'b1;
            if ((item.data != {1'b0, st.last_level_write}) && (nv != 7'd0)) begin
              res.overclock_hint = HINT_SET;
            end
            st_nxt.last_level_write = nv;
          end
          REG_ADDR: begin
            st_nxt.sample_start = {SAMPLE_BASE[15:14], item.data, 6'd0};
            if (item.data != 8'd0) res.overclock_hint = HINT_CLEAR;
          end
          default: begin
            st_nxt.sample_len = {item.data, 4'b0001};
            if (item.data != 8'd0) res.overclock_hint = HINT_CLEAR;
          end
        endcase
      end
      OP_DMA: begin
        if (st_nxt.bytes_left != 12'd0) begin
          st_nxt.read_buf   = item.data;
          st_nxt.buf_empty  = 1'b0;
          st_nxt.fetch_addr = (addr_inc == 16'd0) ? FETCH_WRAP : addr_inc;
          st_nxt.bytes_left = st_nxt.bytes_left - 12'd1;
          if (st_nxt.bytes_left == 12'd0) begin
            if (st_nxt.loop_on) begin
              st_nxt.fetch_addr = st_nxt.sample_start;
              st_nxt.bytes_left = st_nxt.sample_len;
            end else if (st_nxt.irq_on) begin
              res.irq_raise = 1'b1;
            end
          end
        end
        // single-byte sample duplication paths
        if ((st_nxt.sample_len == 12'd1) && !st_nxt.loop_on) begin
          if ((st_nxt.bits_left == BITS_PER_BYTE) &&
              (st_nxt.timer_count == st_nxt.timer_period) &&
              cfg.duplication_glitch_enable) begin
            st_nxt.shifter    = st_nxt.read_buf;
            st_nxt.silent     = 1'b0;
            st_nxt.buf_empty  = 1'b1;
            st_nxt.fetch_addr = st_nxt.sample_start;
            st_nxt.bytes_left = st_nxt.sample_len;
            req = req | try_fetch(st_nxt);
          end else if ((st_nxt.bits_left == 4'd1) && (st_nxt.timer_count < 10'd2)) begin
            st_nxt.shifter    = st_nxt.read_buf;
            st_nxt.buf_empty  = 1'b0;
            st_nxt.fetch_addr = st_nxt.sample_start;
            st_nxt.bytes_left = st_nxt.sample_len;
            st_nxt.stop_delay = STOP_GLITCH;
          end
        end
      end
      OP_ENABLE: begin
        if (!item.enable) begin
          if (st_nxt.stop_delay == 2'd0) st_nxt.stop_delay = delay;
        end else if (st_nxt.bytes_left == 12'd0) begin
          st_nxt.fetch_addr  = st_nxt.sample_start;
          st_nxt.bytes_left  = st_nxt.sample_len;
          st_nxt.start_delay = delay;
        end
      end
      OP_SRESET: begin
        st_nxt              = STATE_RESET;
        st_nxt.sample_start = st.sample_start;
        st_nxt.sample_len   = st.sample_len;
        st_nxt.timer_period = item.rate_period;
        st_nxt.timer_count  = item.rate_period;
      end
      default: begin
      end
    endcase
    res.dma_request = req;
    res.level       = st_nxt.out_level;
    res.dma_address = st_nxt.fetch_addr;
    res.active      = (st_nxt.bytes_left != 12'd0);
  end

endmodule

FILE: design/dpcm_chk.sv
`timescale 1ns / 1ps
`include "dpcm_sample_playback_channel_defines.svh"

module dpcm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  out_level,
  input logic        out_level_valid,
  input logic        out_dma_request,
  input logic [15:0] out_dma_address,
  input logic        out_dma_stop,
  input logic        out_irq_raise,
  input logic        out_irq_clear,
  input logic        out_active
);

  // a stalled result beat keeps its level and address
  `DPCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_level) && $stable(out_dma_address), "stalled beat changed")

  // the stop countdown empties the sample, so no fetch can start with it
  `DPCM_ASSERT_NOW(a_stop_idle, out_valid && out_dma_stop,
    !out_dma_request && !out_active, "fetch or activity on stop beat")

  // irq set comes from a fetch, irq clear from a flags write
  `DPCM_ASSERT_NOW(a_irq_excl, out_valid, !(out_irq_raise && out_irq_clear),
    "irq raise and clear together")

  // new levels come from ticks or level writes, never with irq pulses
  `DPCM_ASSERT_NOW(a_lvl_no_irq, out_valid && out_level_valid,
    !out_irq_raise && !out_irq_clear, "irq pulse on a level beat")

endmodule

bind dpcm_sample_playback_channel dpcm_chk u_dpcm_chk (.*);

FILE: tb/dpcm_channel_checker.sv
`timescale 1ns / 1ps

module dpcm_channel_checker
  import dpcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [2:0]            in_opcode,
  input  logic [1:0]            in_reg_index,
  input  logic [7:0]            in_data,
  input  logic [9:0]            in_rate_period,
  input  logic                  in_odd_cycle,
  input  logic                  in_enable,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [6:0]            out_level,
  input  logic                  out_level_valid,
  input  logic                  out_dma_request,
  input  logic [15:0]           out_dma_address,
  input  logic                  out_dma_stop,
  input  logic                  out_irq_raise,
  input  logic                  out_irq_clear,
  input  logic                  out_active,
  input  logic [1:0]            out_overclock_hint,
  output int                    fail_count,
  output int                    pending
);

  dpcm_state_t  chan;
  dpcm_cfg_t    mode;
  dpcm_result_t due_status_q[$];
  dpcm_result_t due;
  int           errors = 0;

  function automatic bit fetch_due();
    return chan.buf_empty && (chan.bytes_left != 12'd0);
  endfunction

  function automatic void restart_sample();
    chan.fetch_addr = chan.sample_start;
    chan.bytes_left = chan.sample_len;
  endfunction

  function automatic dpcm_result_t advance_channel(dpcm_item_t it);
    dpcm_result_t r;
    logic [1:0]   dly;
    logic         shift_bit;
    logic [15:0]  kept_start;
    logic [11:0]  kept_len;
    int           nv;
    int           d;
    int           lv;
    r   = '0;
    dly = it.odd_cycle ? 2'd3 : 2'd2;
    case (it.opcode)
      OP_TICK: begin
        // stop delay first, then start delay, then the period timer
        if (chan.stop_delay != 2'd0) begin
          chan.stop_delay = chan.stop_delay - 2'd1;
          if (chan.stop_delay == 2'd0) begin
            chan.bytes_left = 12'd0;
            r.dma_stop      = 1'b1;
          end
        end
        if (chan.start_delay != 2'd0) begin
          chan.start_delay = chan.start_delay - 2'd1;
          if (chan.start_delay == 2'd0) r.dma_request = r.dma_request | fetch_due();
        end
        if (chan.timer_count == 10'd0) begin
          chan.timer_count = chan.timer_period;
          if (!chan.silent) begin
            if (mode.reverse_bit_order) begin
              shift_bit    = chan.shifter[7];
              chan.shifter = chan.shifter << 1;
            end else begin
              shift_bit    = chan.shifter[0];
              chan.shifter = chan.shifter >> 1;
            end
            if (shift_bit) begin
              if (chan.out_level <= LEVEL_TOP) chan.out_level = chan.out_level + LEVEL_STEP;
            end else if (chan.out_level >= LEVEL_STEP) begin
              chan.out_level = chan.out_level - LEVEL_STEP;
            end
          end
          chan.bits_left = chan.bits_left - 4'd1;
          if (chan.bits_left == 4'd0) begin
            chan.bits_left = BITS_PER_BYTE;
            if (chan.buf_empty) begin
              chan.silent = 1'b1;
            end else begin
              chan.silent    = 1'b0;
              chan.shifter   = chan.read_buf;
              chan.buf_empty = 1'b1;
              if (chan.start_delay == 2'd0) r.dma_request = r.dma_request | fetch_due();
            end
          end
          r.level_valid = 1'b1;
        end else begin
          chan.timer_count = chan.timer_count - 10'd1;
        end
      end
      OP_WRITE: begin
        case (it.reg_index)
          REG_FLAGS: begin
            chan.irq_on       = it.data[7];
            chan.loop_on      = it.data[6];
            chan.timer_period = it.rate_period;
            if (!chan.irq_on) r.irq_clear = 1'b1;
          end
          REG_LEVEL: begin
            nv = int'(it.data[6:0]);
            d  = nv - int'(chan.out_level);
            lv = nv;
            if (mode.reduce_popping && (d > int'(POP_LIMIT) || d < -int'(POP_LIMIT)))
              lv = nv - d / 2;
            chan.out_level = 7'(lv);
            r.level_valid  = 1'b1;
            // full byte against the stored 7-bit value
            if ({1'b0, chan.last_level_write} != it.data && nv > 0)
              r.overclock_hint = HINT_SET;
            chan.last_level_write = it.data[6:0];
          end
          REG_ADDR: begin
            chan.sample_start = SAMPLE_BASE | {2'b00, it.data, 6'd0};
            if (it.data != 8'd0) r.overclock_hint = HINT_CLEAR;
          end
          default: begin
            chan.sample_len = {it.data, 4'b0001};
            if (it.data != 8'd0) r.overclock_hint = HINT_CLEAR;
          end
        endcase
      end
      OP_DMA: begin
        if (chan.bytes_left != 12'd0) begin
          chan.read_buf   = it.data;
          chan.buf_empty  = 1'b0;
          chan.fetch_addr = chan.fetch_addr + 16'd1;
          if (chan.fetch_addr == 16'd0) chan.fetch_addr = FETCH_WRAP;
          chan.bytes_left = chan.bytes_left - 12'd1;
          if (chan.bytes_left == 12'd0) begin
            if (chan.loop_on) restart_sample();
            else if (chan.irq_on) r.irq_raise = 1'b1;
          end
        end
        // one-byte sample duplication paths
        if (chan.sample_len == 12'd1 && !chan.loop_on) begin
          if (chan.bits_left == BITS_PER_BYTE && chan.timer_count == chan.timer_period &&
              mode.duplication_glitch_enable) begin
            chan.shifter   = chan.read_buf;
            chan.silent    = 1'b0;
            chan.buf_empty = 1'b1;
            restart_sample();
            r.dma_request = r.dma_request | fetch_due();
          end else if (chan.bits_left == 4'd1 && chan.timer_count < 10'd2) begin
            chan.shifter   = chan.read_buf;
            chan.buf_empty = 1'b0;
            restart_sample();
            chan.stop_delay = STOP_GLITCH;
          end
        end
      end
      OP_ENABLE: begin
        if (!it.enable) begin
          if (chan.stop_delay == 2'd0) chan.stop_delay = dly;
        end else if (chan.bytes_left == 12'd0) begin
          restart_sample();
          chan.start_delay = dly;
        end
      end
      OP_SRESET: begin
        kept_start        = chan.sample_start;
        kept_len          = chan.sample_len;
        chan              = STATE_RESET;
        chan.sample_start = kept_start;
        chan.sample_len   = kept_len;
        chan.timer_period = it.rate_period;
        chan.timer_count  = it.rate_period;
      end
      default: ;
    endcase
    r.level       = chan.out_level;
    r.dma_address = chan.fetch_addr;
    r.active      = (chan.bytes_left != 12'd0);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      chan = STATE_RESET;
      mode = CFG_RESET;
      due_status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REVERSE: mode.reverse_bit_order         = cfg_data[0];
          CFG_GLITCH:  mode.duplication_glitch_enable = cfg_data[0];
          CFG_POP:     mode.reduce_popping            = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        due_status_q.push_back(advance_channel('{in_opcode, in_reg_index, in_data,
                                                 in_rate_period, in_odd_cycle, in_enable}));
      if (out_valid && out_ready) begin
        if (due_status_q.size() == 0) begin
          $error("result beat with no expected status");
          errors++;
        end else begin
          due = due_status_q.pop_front();
          check_field("level", 32'(due.level), 32'(out_level));
          check_field("level_valid", 32'(due.level_valid), 32'(out_level_valid));
          check_field("dma_request", 32'(due.dma_request), 32'(out_dma_request));
          check_field("dma_address", 32'(due.dma_address), 32'(out_dma_address));
          check_field("dma_stop", 32'(due.dma_stop), 32'(out_dma_stop));
          check_field("irq_raise", 32'(due.irq_raise), 32'(out_irq_raise));
          check_field("irq_clear", 32'(due.irq_clear), 32'(out_irq_clear));
          check_field("active", 32'(due.active), 32'(out_active));
          check_field("overclock_hint", 32'(due.overclock_hint), 32'(out_overclock_hint));
        end
      end
    end
    fail_count <= errors;
    pending    <= due_status_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dpcm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            in_opcode;
  logic [1:0]            in_reg_index;
  logic [7:0]            in_data;
  logic [9:0]            in_rate_period;
  logic                  in_odd_cycle;
  logic                  in_enable;
  logic                  out_valid;
  logic                  out_ready;
  logic [6:0]            out_level;
  logic                  out_level_valid;
  logic                  out_dma_request;
  logic [15:0]           out_dma_address;
  logic                  out_dma_stop;
  logic                  out_irq_raise;
  logic                  out_irq_clear;
  logic                  out_active;
  logic [1:0]            out_overclock_hint;
  int                    fail_count;
  int                    pending;

  int send_idle_pct = 21;
  int recv_idle_pct = 50;
  int beats_sent    = 0;

  dpcm_sample_playback_channel u_top (.*);
  dpcm_channel_checker u_checker (.*);

  always #10 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input logic [2:0] opc, input logic [1:0] ri, input logic [7:0] dat,
                           input logic [9:0] rp, input logic odd, input logic en);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= opc;
    in_reg_index   <= ri;
    in_data        <= dat;
    in_rate_period <= rp;
    in_odd_cycle   <= odd;
    in_enable      <= en;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n)
      send_item(OP_TICK, 2'($urandom), 8'($urandom), 10'($urandom), 1'($urandom),
                1'($urandom));
  endtask

  // hold the sender until every status beat is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_modes(input logic rev, input logic glitch, input logic pop);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REVERSE;
    cfg_data  <= rev;
    @(posedge clk);
    cfg_index <= CFG_GLITCH;
    cfg_data  <= glitch;
    @(posedge clk);
    cfg_index <= CFG_POP;
    cfg_data  <= pop;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // program and enable a sample, then mix ticks with fetches, enables and writes
  task automatic play_sequence();
    bit long_run;
    int steps;
    int pick;
    long_run = ($urandom_range(99) < 6);
    if (long_run || $urandom_range(99) < 70)
      send_item(OP_SRESET, 2'($urandom), 8'($urandom), 10'($urandom_range(3)), 1'($urandom),
                1'($urandom));
    send_item(OP_WRITE, REG_FLAGS, 8'($urandom), 10'($urandom_range(3)), 1'($urandom),
              1'($urandom));
    send_item(OP_WRITE, REG_ADDR, long_run ? 8'hFF : 8'($urandom), 10'($urandom),
              1'($urandom), 1'($urandom));
    if (long_run)
      send_item(OP_WRITE, REG_LEN, 8'($urandom_range(4, 255)), 10'($urandom), 1'($urandom),
                1'($urandom));
    else
      send_item(OP_WRITE, REG_LEN, $urandom_range(1) ? 8'd0 : 8'($urandom_range(1, 3)),
                10'($urandom), 1'($urandom), 1'($urandom));
    if ($urandom_range(1))
      send_item(OP_WRITE, REG_LEVEL, 8'($urandom), 10'($urandom), 1'($urandom), 1'($urandom));
    send_item(OP_ENABLE, 2'($urandom), 8'($urandom), 10'($urandom), 1'($urandom), 1'b1);
    steps = long_run ? 160 : int'($urandom_range(20, 60));
    repeat (steps) begin
      pick = int'($urandom_range(99));
      if (pick < (long_run ? 40 : 65))
        send_ticks(1);
      else if (pick < 88)
        send_item(OP_DMA, 2'($urandom), 8'($urandom), 10'($urandom), 1'($urandom),
                  1'($urandom));
      else if (pick < 93)
        send_item(OP_ENABLE, 2'($urandom), 8'($urandom), 10'($urandom), 1'($urandom),
                  1'($urandom));
      else
        send_item(OP_WRITE, 2'($urandom), 8'($urandom), 10'($urandom_range(3)),
                  1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_REVERSE;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_TICK;
    in_reg_index   <= REG_FLAGS;
    in_data        <= 8'd0;
    in_rate_period <= 10'd0;
    in_odd_cycle   <= 1'b0;
    in_enable      <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_modes(1'b0, 1'b0, 1'b0);

    // directed: timer reloads, level write hints, empty fetch, irq, stop, bad opcodes
    send_ticks(1);
    send_item(OP_SRESET, REG_FLAGS, 8'h00, 10'h3FF, 1'b0, 1'b0);
    send_item(OP_SRESET, REG_FLAGS, 8'h00, 10'h000, 1'b0, 1'b0);
    send_item(OP_WRITE, REG_FLAGS, 8'h80, 10'h000, 1'b0, 1'b0);
    send_item(OP_WRITE, REG_LEVEL, 8'hFF, 10'h000, 1'b0, 1'b0);
    send_item(OP_WRITE, REG_LEVEL, 8'h7F, 10'h000, 1'b0, 1'b0);
    send_item(OP_WRITE, REG_LEVEL, 8'h00, 10'h000, 1'b0, 1'b0);
    send_item(OP_WRITE, REG_ADDR, 8'hFF, 10'h000, 1'b0, 1'b0);
    send_item(OP_WRITE, REG_ADDR, 8'h00, 10'h000, 1'b0, 1'b0);
    send_item(OP_WRITE, REG_LEN, 8'hFF, 10'h000, 1'b0, 1'b0);
    send_item(OP_WRITE, REG_LEN, 8'h00, 10'h000, 1'b0, 1'b0);
    send_item(OP_DMA, REG_FLAGS, 8'hA5, 10'h000, 1'b0, 1'b0);
    send_item(OP_ENABLE, REG_FLAGS, 8'h00, 10'h000, 1'b1, 1'b1);
    send_ticks(3);
    send_item(OP_DMA, REG_FLAGS, 8'hFF, 10'h000, 1'b0, 1'b0);
    send_ticks(2);
    send_item(OP_ENABLE, REG_FLAGS, 8'h00, 10'h000, 1'b0, 1'b0);
    send_ticks(2);
    send_item(OP_WRITE, REG_FLAGS, 8'h40, 10'h3FF, 1'b1, 1'b1);
    for (int k = int'(OP_SRESET) + 1; k < 8; k++)
      send_item(3'(k), REG_LEN, 8'hFF, 10'h3FF, 1'b1, 1'b1);

    for (int seg = 0; seg < 6; seg++) begin
      settle();
      case (seg / 2)
        0: begin send_idle_pct = 21; recv_idle_pct = 50; end
        1: begin send_idle_pct = 50; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (seg)
        0: write_modes(1'b0, 1'b0, 1'b0);
        1: write_modes(1'b1, 1'b1, 1'b1);
        2: write_modes(1'b1, 1'b0, 1'b1);
        3: write_modes(1'b0, 1'b1, 1'b0);
        default: write_modes(1'($urandom), 1'($urandom), 1'($urandom));
      endcase
      while (beats_sent < 25 + (seg + 1) * 285) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(5, 15))
            send_item(3'($urandom), 2'($urandom), 8'($urandom), 10'($urandom),
                      1'($urandom), 1'($urandom));
        end else begin
          play_sequence();
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
